>>> design/pve_pkg.sv
// shared types and constants of the position and velocity estimator
package pve_pkg;

    // field widths
    localparam int MV_W       = 15;
    localparam int POS_W      = 21;
    localparam int VEL_W      = 25;
    localparam int TGT_W      = 25;
    localparam int MVC_W      = 24;
    localparam int ALPHA_W    = 17;
    localparam int MIN_DT_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // divider: |dpos * 1000| always fits this many bits
    localparam int DIV_BITS = 32;
    localparam int CNT_W    = $clog2(DIV_BITS);

    // arithmetic constants
    localparam int POS_OFFSET_MV = 10000;
    localparam int POS_GAIN      = 65;
    localparam int VEL_SCALE     = 1000;
    localparam int ALPHA_SHIFT   = 16;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 25'sd16777215;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_TARGET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_POSITION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VELOCITY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL_CHANGE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q16      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DT_MS      = 3'd6;

    // register reset values
    localparam logic [MVC_W-1:0]    RST_MAX_VEL_CHANGE = 24'd200000;
    localparam logic [ALPHA_W-1:0]  RST_ALPHA_Q16      = 17'd13107;
    localparam logic [MIN_DT_W-1:0] RST_MIN_DT_MS      = 10'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_CLAMP,
        ST_MUL,
        ST_FIN,
        ST_OUT
    } t_state;

endpackage

>>> design/pve_channels.sv
// channel interfaces: samples in, results out, register writes
interface pve_sample_if
    import pve_pkg::*;
#(
    parameter int TIME_BITS = 48
);
    logic                        valid;
    logic                        ready;
    logic [TIME_BITS-1:0]        sample_time;
    logic signed [MV_W-1:0]      sensor_mv;

    modport source (output valid, output sample_time, output sensor_mv, input ready);
    modport sink   (input valid, input sample_time, input sensor_mv, output ready);
endinterface

interface pve_result_if
    import pve_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [POS_W-1:0]     position_um;
    logic signed [VEL_W-1:0]     velocity_ums;
    logic signed [TGT_W-1:0]     position_setpoint;
    logic signed [TGT_W-1:0]     velocity_setpoint;

    modport source (output valid, output position_um, output velocity_ums,
                    output position_setpoint, output velocity_setpoint, input ready);
    modport sink   (input valid, input position_um, input velocity_ums,
                    input position_setpoint, input velocity_setpoint, output ready);
endinterface

interface pve_cfg_if
    import pve_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic [CFG_IDX_W-1:0]        index;
    logic [CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/position_velocity_estimator.sv
// position and velocity estimator: sensor scaling, radix-2 serial divider, slew limit, ema
// sequence: a sample runs through prep, div, clamp, mul, fin and out when velocity is updated,
//           and through prep and out when the gap is too short and the last velocity is kept
// throughput: a new sample is taken only in idle, after the last result has been loaded; the
//             32-step divider for dpos*1000/dt produces one quotient bit per cycle
// reset: synchronous active low, config and control registers return to defaults; first sample
//        reloads position and velocity from the init registers and its own time; no clearing pass
module position_velocity_estimator
    import pve_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pve_sample_if.sink    i_sample,
    pve_result_if.source  o_result,
    pve_cfg_if.sink       i_cfg
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic                       r_mode;
    logic signed [TGT_W-1:0]    r_target;
    logic signed [POS_W-1:0]    r_init_pos;
    logic signed [VEL_W-1:0]    r_init_vel;
    logic [MVC_W-1:0]           r_mvc;
    logic [ALPHA_W-1:0]         r_alpha;
    logic [MIN_DT_W-1:0]        r_min_dt;

    // register writes are always taken; unknown indexes fall away
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_target   <= '0;
            r_init_pos <= '0;
            r_init_vel <= '0;
            r_mvc      <= RST_MAX_VEL_CHANGE;
            r_alpha    <= RST_ALPHA_Q16;
            r_min_dt   <= RST_MIN_DT_MS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CONTROL_MODE:   r_mode     <= i_cfg.data[0];
                CFG_AXIS_TARGET:    r_target   <= i_cfg.data[TGT_W-1:0];
                CFG_INIT_POSITION:  r_init_pos <= i_cfg.data[POS_W-1:0];
                CFG_INIT_VELOCITY:  r_init_vel <= i_cfg.data[VEL_W-1:0];
                CFG_MAX_VEL_CHANGE: r_mvc      <= i_cfg.data[MVC_W-1:0];
                CFG_ALPHA_Q16:      r_alpha    <= i_cfg.data[ALPHA_W-1:0];
                CFG_MIN_DT_MS:      r_min_dt   <= i_cfg.data[MIN_DT_W-1:0];
                default:            ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    t_state               r_state, n_state;
    logic                 r_seen;
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_cnt;

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    logic [TIME_BITS-1:0]       r_t;            // timestamp of the sample in work
    logic signed [POS_W-1:0]    r_pos;          // its position
    logic signed [POS_W-1:0]    r_prev_pos;
    logic signed [VEL_W-1:0]    r_prev_vel;
    logic [TIME_BITS-1:0]       r_prev_time;
    logic signed [VEL_W-1:0]    r_last;         // saturated last velocity
    logic signed [VEL_W-1:0]    r_vel;          // velocity to be stored and sent
    logic                       r_neg;          // sign of dpos*1000
    logic                       r_big;          // gap beyond divider width, quotient 0
    logic [DIV_BITS-1:0]        r_quo;          // dividend shifts out, quotient shifts in
    logic [DIV_BITS-1:0]        r_rem;
    logic [DIV_BITS-1:0]        r_div;
    logic signed [VEL_W-1:0]    r_diff;         // clamped raw minus last
    logic signed [41:0]         r_prod;         // diff * alpha

    logic signed [POS_W-1:0]    r_out_pos;
    logic signed [VEL_W-1:0]    r_out_vel;
    logic signed [TGT_W-1:0]    r_out_psp;
    logic signed [TGT_W-1:0]    r_out_vsp;

    // ---------------------------------------------------------------
    // combinational datapath
    // ---------------------------------------------------------------
    logic                       sample_txn;
    logic                       out_free;
    logic signed [15:0]         mv_diff;
    logic signed [21:0]         pos_x;
    logic signed [21:0]         pos_r;
    logic signed [21:0]         pos_half;
    logic signed [POS_W-1:0]    pos_c;
    logic [TIME_BITS:0]         dt_ext;
    logic [TIME_BITS-1:0]       dt;
    logic                       upd;
    logic                       big_c;
    logic signed [21:0]         dpos;
    logic signed [31:0]         num;
    logic [DIV_BITS-1:0]        num_abs;
    logic signed [VEL_W-1:0]    last_c;
    logic [DIV_BITS:0]          rem_sh;
    logic                       q_bit;
    logic [DIV_BITS:0]          rem_sub;
    logic signed [33:0]         q34;
    logic signed [33:0]         raw34;
    logic signed [33:0]         last34;
    logic signed [33:0]         mvc34;
    logic signed [33:0]         hi34;
    logic signed [33:0]         lo34;
    logic signed [33:0]         rawc;
    logic signed [33:0]         diff34;
    logic signed [42:0]         prod;
    logic signed [41:0]         adj;
    logic signed [26:0]         sum27;
    logic signed [VEL_W-1:0]    vel_c;

    assign out_free = !r_out_valid || o_result.ready;

    always_comb begin
        // position: (10000 - mv) * 65 / 2, halved toward zero
        mv_diff  = 16'(POS_OFFSET_MV) - 16'(i_sample.sensor_mv);
        pos_x    = 22'(mv_diff) * 22'(POS_GAIN);
        pos_r    = pos_x + $signed({21'd0, pos_x[21]});
        pos_half = pos_r >>> 1;
        pos_c    = pos_half[POS_W-1:0];

        // gap: borrow means time went backwards
        dt_ext = {1'b0, r_t} - {1'b0, r_prev_time};
        dt     = dt_ext[TIME_BITS-1:0];
        upd    = !dt_ext[TIME_BITS] && (dt > TIME_BITS'(r_min_dt));
        big_c  = (dt >> DIV_BITS) != '0;

        // dividend
        dpos    = 22'(r_pos) - 22'(r_prev_pos);
        num     = 32'(dpos) * 32'(VEL_SCALE);
        num_abs = num[31] ? DIV_BITS'(-num) : DIV_BITS'(num);

        // last velocity, full-scale negative init value pulled into range
        last_c = (r_prev_vel < -VEL_MAX) ? -VEL_MAX : r_prev_vel;

        // one restoring divide step
        rem_sh  = {r_rem, r_quo[DIV_BITS-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        q_bit   = !rem_sub[DIV_BITS];

        // slew limit around the last velocity
        q34    = r_big ? '0 : $signed({2'b00, r_quo});
        raw34  = r_neg ? -q34 : q34;
        last34 = 34'(r_last);
        mvc34  = $signed({10'd0, r_mvc});
        hi34   = last34 + mvc34;
        lo34   = last34 - mvc34;
        rawc   = (raw34 > hi34) ? hi34 : raw34;
        rawc   = (rawc < lo34) ? lo34 : rawc;
        diff34 = rawc - last34;

        // filter weight
        prod = 43'(r_diff) * $signed({26'd0, r_alpha});

        // flooring shift, add, saturate
        adj   = r_prod >>> ALPHA_SHIFT;
        sum27 = 27'(r_last) + 27'($signed(adj[25:0]));
        if (sum27 > 27'(VEL_MAX)) begin
            vel_c = VEL_MAX;
        end else if (sum27 < -27'(VEL_MAX)) begin
            vel_c = -VEL_MAX;
        end else begin
            vel_c = sum27[VEL_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // state machine: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (sample_txn) n_state = ST_PREP;
            ST_PREP:  n_state = upd ? ST_DIV : ST_OUT;
            ST_DIV:   if (r_cnt == CNT_W'(DIV_BITS - 1)) n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_MUL;
            ST_MUL:   n_state = ST_FIN;
            ST_FIN:   n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // state machine: outputs
    // ---------------------------------------------------------------
    always_comb begin
        case (r_state)
            ST_IDLE: i_sample.ready = 1'b1;
            default: i_sample.ready = 1'b0;
        endcase
    end

    assign sample_txn = i_sample.valid && i_sample.ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (sample_txn) begin
                r_seen <= 1'b1;
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (sample_txn) begin
                    r_t   <= i_sample.sample_time;
                    r_pos <= pos_c;
                    // first sample after reset takes the init registers as the previous state, with its own time
                    if (!r_seen) begin
                        r_prev_pos  <= r_init_pos;
                        r_prev_vel  <= r_init_vel;
                        r_prev_time <= i_sample.sample_time;
                    end
                end
            end
            ST_PREP: begin
                r_last <= last_c;
                r_vel  <= last_c;
                r_neg  <= num[31];
                r_big  <= big_c;
                r_quo  <= num_abs;
                r_rem  <= '0;
                r_div  <= dt[DIV_BITS-1:0];
            end
            ST_DIV: begin
                r_quo <= {r_quo[DIV_BITS-2:0], q_bit};
                r_rem <= q_bit ? rem_sub[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
            end
            ST_CLAMP: begin
                r_diff <= diff34[VEL_W-1:0];
            end
            ST_MUL: begin
                r_prod <= prod[41:0];
            end
            ST_FIN: begin
                r_vel <= vel_c;
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_pos   <= r_pos;
                    r_out_vel   <= r_vel;
                    r_out_psp   <= r_mode ? '0 : r_target;
                    r_out_vsp   <= r_mode ? r_target : '0;
                    r_prev_pos  <= r_pos;
                    r_prev_vel  <= r_vel;
                    r_prev_time <= r_t;
                end
            end
            default: ;
        endcase
    end

    // result transaction
    assign o_result.valid             = r_out_valid;
    assign o_result.position_um       = r_out_pos;
    assign o_result.velocity_ums      = r_out_vel;
    assign o_result.position_setpoint = r_out_psp;
    assign o_result.velocity_setpoint = r_out_vsp;

`ifndef SYNTHESIS
    // a sample transaction always starts the gap computation
    a_txn_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample_txn |=> (r_state == ST_PREP))
        else $error("sample transaction did not start processing");

    // the result register is loaded as soon as it is free
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> o_result.valid)
        else $error("result not presented after completion");

    // restoring divider keeps its remainder below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !r_big) |-> (r_rem < r_div))
        else $error("divider remainder out of range");

    // stored velocity is saturated once a sample has been processed
    a_vel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen && r_state == ST_IDLE) |-> (r_prev_vel >= -VEL_MAX))
        else $error("stored velocity outside its range");
`endif

endmodule

>>> bench/position_velocity_estimator_test.sv
`timescale 1ns / 1ps
// self-checking bench for the position and velocity estimator, with its own estimate model
module position_velocity_estimator_test;
    import pve_pkg::*;

    localparam int TB_TIME_BITS  = 48;
    localparam int CLK_PERIOD    = 20;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int IDLE_PCT      = 13;
    localparam int HOLD_AT       = 360;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASES        = 6;
    localparam int REPORT_MAX    = 10;

    localparam longint VEL_LIMIT = 64'sd16777215;
    // gaps at or beyond this give a raw velocity of zero
    localparam logic [63:0] LONG_GAP = 64'h0000_0100_0000_0000;

    typedef struct {
        logic signed [POS_W-1:0] pos;
        logic signed [VEL_W-1:0] vel;
        logic signed [TGT_W-1:0] pos_sp;
        logic signed [TGT_W-1:0] vel_sp;
    } t_estimate;

    // mirrors the estimator: registers, last sample state and the estimates still owed
    class estimator_scoreboard;
        bit                         mode;
        logic signed [TGT_W-1:0]    target;
        logic signed [POS_W-1:0]    init_pos;
        logic signed [VEL_W-1:0]    init_vel;
        logic [MVC_W-1:0]           max_step;
        logic [ALPHA_W-1:0]         alpha;
        logic [MIN_DT_W-1:0]        min_dt;

        logic signed [POS_W-1:0]    last_pos;
        logic signed [VEL_W-1:0]    last_vel;
        logic [TB_TIME_BITS-1:0]    last_stamp;
        bit                         primed;

        t_estimate                  owed_estimates[$];
        int                         mismatches;
        int                         checked;

        function new();
            mode       = 1'b0;
            target     = '0;
            init_pos   = '0;
            init_vel   = '0;
            max_step   = RST_MAX_VEL_CHANGE;
            alpha      = RST_ALPHA_Q16;
            min_dt     = RST_MIN_DT_MS;
            last_pos   = '0;
            last_vel   = '0;
            last_stamp = '0;
            primed     = 1'b0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_CONTROL_MODE:   mode     = value[0];
                CFG_AXIS_TARGET:    target   = value[TGT_W-1:0];
                CFG_INIT_POSITION:  init_pos = value[POS_W-1:0];
                CFG_INIT_VELOCITY:  init_vel = value[VEL_W-1:0];
                CFG_MAX_VEL_CHANGE: max_step = value[MVC_W-1:0];
                CFG_ALPHA_Q16:      alpha    = value[ALPHA_W-1:0];
                CFG_MIN_DT_MS:      min_dt   = value[MIN_DT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_vel(longint v);
            if (v > VEL_LIMIT) return VEL_LIMIT;
            if (v < -VEL_LIMIT) return -VEL_LIMIT;
            return v;
        endfunction

        function void note_sample(logic [TB_TIME_BITS-1:0] stamp, logic signed [MV_W-1:0] mv);
            longint    pos;
            longint    held;
            longint    raw;
            longint    num;
            longint    dt;
            longint    step;
            longint    mvc;
            longint    vel;
            t_estimate e;
            pos = ((POS_OFFSET_MV - longint'(mv)) * POS_GAIN) / 2;
            // first sample after reset: start from the init registers, gap of zero
            if (!primed) begin
                last_pos   = init_pos;
                last_vel   = init_vel;
                last_stamp = stamp;
                primed     = 1'b1;
            end
            held = clamp_vel(longint'(last_vel));
            if (stamp > last_stamp && (stamp - last_stamp) > min_dt) begin
                dt  = longint'(stamp - last_stamp);
                num = (pos - longint'(last_pos)) * VEL_SCALE;
                raw = (dt >= LONG_GAP) ? 0 : num / dt;
                mvc = longint'(max_step);
                if (raw > held + mvc) raw = held + mvc;
                if (raw < held - mvc) raw = held - mvc;
                step = ((raw - held) * longint'(alpha)) >>> ALPHA_SHIFT;
                vel  = clamp_vel(held + step);
            end else begin
                vel = held;
            end
            last_pos   = pos[POS_W-1:0];
            last_vel   = vel[VEL_W-1:0];
            last_stamp = stamp;
            e.pos    = pos[POS_W-1:0];
            e.vel    = vel[VEL_W-1:0];
            e.pos_sp = mode ? '0 : target;
            e.vel_sp = mode ? target : '0;
            owed_estimates.push_back(e);
        endfunction

        function void check_estimate(t_estimate got);
            t_estimate want;
            if (owed_estimates.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result transaction: pos %0d vel %0d psp %0d vsp %0d",
                             got.pos, got.vel, got.pos_sp, got.vel_sp);
                return;
            end
            want = owed_estimates.pop_front();
            checked++;
            if (got.pos !== want.pos || got.vel !== want.vel ||
                got.pos_sp !== want.pos_sp || got.vel_sp !== want.vel_sp) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("result %0d differs: expected pos %0d vel %0d psp %0d vsp %0d",
                             checked, want.pos, want.vel, want.pos_sp, want.vel_sp);
                    $display("    got pos %0d vel %0d psp %0d vsp %0d",
                             got.pos, got.vel, got.pos_sp, got.vel_sp);
                end
            end
        endfunction

        function int outstanding();
            return owed_estimates.size();
        endfunction

        function void flag_leftovers();
            if (owed_estimates.size() != 0) begin
                mismatches += owed_estimates.size();
                $display("%0d expected results never arrived", owed_estimates.size());
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pve_sample_if #(.TIME_BITS(TB_TIME_BITS)) sample_ch ();
    pve_result_if                             result_ch ();
    pve_cfg_if                                reg_ch ();

    position_velocity_estimator #(.TIME_BITS(TB_TIME_BITS)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .i_cfg    (reg_ch)
    );

    estimator_scoreboard sb = new();

    // stimulus state
    logic [TB_TIME_BITS-1:0] stamp;
    int                      level_mv;
    int                      gap_floor;
    bit                      steady;
    int                      samples_taken;
    int                      reg_writes;
    int                      settings_used;
    int                      hold_left;
    bit                      hold_done;

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // watchdog: a generous fixed budget well beyond the slowest legal run
    initial begin
        #(CYCLE_LIMIT * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

    // monitors: every transaction is sampled at the edge that completes it
    always @(posedge i_clk) begin
        if (i_rst_n && sample_ch.valid && sample_ch.ready) begin
            sb.note_sample(sample_ch.sample_time, sample_ch.sensor_mv);
            samples_taken <= samples_taken + 1;
        end
    end

    always @(posedge i_clk) begin
        t_estimate got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.pos    = result_ch.position_um;
            got.vel    = result_ch.velocity_ums;
            got.pos_sp = result_ch.position_setpoint;
            got.vel_sp = result_ch.velocity_setpoint;
            sb.check_estimate(got);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && reg_ch.valid && reg_ch.ready)
            sb.apply_reg(reg_ch.index, reg_ch.data);
    end

    // result side: random stalls, none in the steady stretch, and one long hold-off
    // so that the estimator backs up and refuses samples for a while
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (!hold_done && samples_taken >= HOLD_AT) begin
            result_ch.ready <= 1'b0;
            hold_left       <= HOLD_CYCLES;
            hold_done       <= 1'b1;
        end else begin
            result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // offers one sample; valid is left high so the next one can follow back to back
    task automatic send_sample(input logic [TB_TIME_BITS-1:0] at_ms,
                               input logic signed [MV_W-1:0] mv);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.sample_time <= at_ms;
        sample_ch.sensor_mv   <= mv;
        do @(posedge i_clk); while (sample_ch.ready !== 1'b1);
    endtask

    // register write; valid stays high until reg_idle so writes can run back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= value;
        do @(posedge i_clk); while (reg_ch.ready !== 1'b1);
        reg_writes++;
    endtask

    task automatic reg_idle();
        reg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering and wait until every estimate owed has been delivered
    // (the monitor notes the last accepted sample before the wait begins)
    task automatic settle();
        int waited;
        waited = 0;
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input bit mode, input logic [TGT_W-1:0] target,
                                  input logic [MVC_W-1:0] mvc,
                                  input logic [ALPHA_W-1:0] alpha,
                                  input logic [MIN_DT_W-1:0] min_dt);
        write_reg(CFG_CONTROL_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_AXIS_TARGET, CFG_DATA_W'(target));
        write_reg(CFG_MAX_VEL_CHANGE, CFG_DATA_W'(mvc));
        write_reg(CFG_ALPHA_Q16, CFG_DATA_W'(alpha));
        write_reg(CFG_MIN_DT_MS, CFG_DATA_W'(min_dt));
        reg_idle();
        gap_floor = min_dt;
        settings_used++;
    endtask

    // random settings per phase, leaning on the extremes
    task automatic random_settings();
        logic [TGT_W-1:0]    target;
        logic [MVC_W-1:0]    mvc;
        logic [ALPHA_W-1:0]  alpha;
        logic [MIN_DT_W-1:0] min_dt;
        case ($urandom_range(0, 3))
            0:       target = 25'h100_0000;
            1:       target = 25'd16777215;
            2:       target = -25'sd16777215;
            default: target = TGT_W'($urandom());
        endcase
        case ($urandom_range(0, 3))
            0:       mvc = '0;
            1:       mvc = '1;
            2:       mvc = MVC_W'($urandom_range(0, 300000));
            default: mvc = MVC_W'($urandom());
        endcase
        case ($urandom_range(0, 4))
            0:       alpha = '0;
            1:       alpha = 17'd65536;
            2:       alpha = '1;
            3:       alpha = RST_ALPHA_Q16;
            default: alpha = ALPHA_W'($urandom_range(0, 65536));
        endcase
        case ($urandom_range(0, 3))
            0:       min_dt = '0;
            1:       min_dt = '1;
            2:       min_dt = MIN_DT_W'($urandom_range(0, 20));
            default: min_dt = MIN_DT_W'($urandom_range(1, 5));
        endcase
        apply_settings(1'($urandom_range(0, 1)), target, mvc, alpha, min_dt);
    endtask

    // mostly a moving axis sampled in time order, with some jumps, reversals and noise
    task automatic random_phase(input int count);
        logic signed [MV_W-1:0] mv;
        int                     pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                stamp = TB_TIME_BITS'({$urandom(), $urandom()});
            else if (pick < 8)
                stamp = stamp - $urandom_range(0, 50);
            else if (pick < 10)
                stamp = TB_TIME_BITS'(stamp + LONG_GAP + $urandom_range(0, 1000));
            else if (pick < 25)
                stamp = stamp + $urandom_range(0, gap_floor + 1);
            else if (pick < 60)
                stamp = stamp + gap_floor + $urandom_range(0, 3);
            else
                stamp = stamp + gap_floor + $urandom_range(1, 40);

            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                level_mv = level_mv + int'($urandom_range(0, 400)) - 200;
                if (level_mv > 12000) level_mv = 12000;
                if (level_mv < -12000) level_mv = -12000;
                mv = MV_W'(level_mv);
            end else if (pick < 90) begin
                mv = MV_W'(int'($urandom_range(0, 24000)) - 12000);
            end else begin
                mv = MV_W'($urandom_range(0, 32767));
            end
            send_sample(stamp, mv);
        end
    endtask

    initial begin
        sample_ch.valid       = 1'b0;
        sample_ch.sample_time = '0;
        sample_ch.sensor_mv   = '0;
        reg_ch.valid          = 1'b0;
        reg_ch.index          = '0;
        reg_ch.data           = '0;
        result_ch.ready       = 1'b0;
        i_rst_n               = 1'b0;
        stamp                 = '0;
        level_mv              = 0;
        gap_floor             = RST_MIN_DT_MS;
        steady                = 1'b0;
        samples_taken         = 0;
        reg_writes            = 0;
        settings_used         = 1;
        hold_left             = 0;
        hold_done             = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // init registers before the first sample; slew, filter and gap stay at reset values.
        // the most negative init velocity must come out saturated
        write_reg(CFG_INIT_POSITION, CFG_DATA_W'(715000));
        write_reg(CFG_INIT_VELOCITY, 25'h100_0000);
        write_reg(CFG_AXIS_TARGET, 25'h100_0000);
        write_reg(CFG_CONTROL_MODE, '0);
        reg_idle();

        // first sample, time standing still, time going backwards, gap equal to the minimum
        send_sample(48'd1000, MV_W'(0));
        send_sample(48'd1000, MV_W'(12000));
        send_sample(48'd999, MV_W'(-12000));
        send_sample(48'd1000, MV_W'(5000));
        // sensor beyond its range at both ends of the 15-bit field
        send_sample(48'd1002, MV_W'(16383));
        send_sample(48'd1005, MV_W'(-16384));
        // gaps so long the raw velocity truncates to zero, either side of the cut-off
        send_sample(TB_TIME_BITS'(48'd1005 + LONG_GAP - 1), MV_W'(16383));
        send_sample(TB_TIME_BITS'(48'd1005 + 2 * LONG_GAP), MV_W'(-16384));
        // top of the time field, then a wrap that reads as going backwards
        send_sample(48'hFFFF_FFFF_FFF0, MV_W'(10000));
        send_sample(48'd5, MV_W'(9999));
        send_sample(48'd8, MV_W'(0));
        settle();

        // velocity mode, alpha above unity, no slew limit, no minimum gap: saturation
        apply_settings(1'b1, 25'd16777215, '1, '1, '0);
        send_sample(48'd9, MV_W'(-16384));
        send_sample(48'd10, MV_W'(16383));
        send_sample(48'd10, MV_W'(0));
        send_sample(48'd11, MV_W'(12000));
        settle();

        // filter shut and slew limit zero, widest minimum gap
        apply_settings(1'b0, -25'sd16777215, '0, '0, '1);
        send_sample(48'd11 + 1023, MV_W'(-12000));
        send_sample(48'd11 + 2047, MV_W'(12000));
        settle();

        // unity filter and open slew: velocity follows the raw difference
        apply_settings(1'b1, '0, '1, 17'd65536, '0);
        send_sample(48'd2059, MV_W'(0));
        send_sample(48'd2060, MV_W'(200));
        send_sample(48'd2062, MV_W'(-200));
        settle();

        stamp    = 48'd5000;
        level_mv = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            random_settings();
            // later init writes must change nothing
            if (phase == 3) begin
                write_reg(CFG_INIT_POSITION, CFG_DATA_W'(-65000));
                write_reg(CFG_INIT_VELOCITY, CFG_DATA_W'($urandom()));
                reg_idle();
            end
            steady = (phase == 2);
            random_phase(PHASE_ITEMS);
            settle();
            steady = 1'b0;
        end

        // a last stretch for anything still in flight
        repeat (40) @(posedge i_clk);
        sb.flag_leftovers();

        $display("covered %0d samples, %0d results checked, over %0d register settings",
                 samples_taken, sb.checked, settings_used);
        $display("%0d register writes, one output hold-off of %0d cycles, %0d mismatches",
                 reg_writes, HOLD_CYCLES, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
